// ===== src/assert_macros.svh =====
// Assertion macros used by the checker module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== src/rrts_pkg.sv =====
// Package for the round-robin thread scheduler: sizes, codes, slot entry type, helpers.
// No dependencies.
`default_nettype none

package rrts_pkg;

    localparam int THREAD_SLOTS = 16;
    localparam int IDX_W = $clog2(THREAD_SLOTS);
    localparam int CNT_W = $clog2(THREAD_SLOTS + 1);

    typedef logic [IDX_W-1:0] slot_idx_t;
    typedef logic [CNT_W-1:0] slot_cnt_t;
    typedef logic [CNT_W:0] slot_sum_t;

    typedef enum logic [1:0] {
        SLOT_UNUSED,
        SLOT_READY,
        SLOT_RUNNING,
        SLOT_BLOCKED
    } slot_state_t;

    typedef struct packed {
        slot_state_t state;
        logic mark;
        logic [31:0] quanta;
        logic [31:0] wake;
    } slot_entry_t;

    localparam int SLOT_W = $bits(slot_entry_t);

    localparam logic [2:0] OP_TICK = 3'd0;
    localparam logic [2:0] OP_SPAWN = 3'd1;
    localparam logic [2:0] OP_TERMINATE = 3'd2;
    localparam logic [2:0] OP_BLOCK = 3'd3;
    localparam logic [2:0] OP_RESUME = 3'd4;
    localparam logic [2:0] OP_SLEEP = 3'd5;
    localparam logic [2:0] OP_QUERY = 3'd6;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_BAD_ID = 3'd1;
    localparam logic [2:0] ST_NO_THREAD = 3'd2;
    localparam logic [2:0] ST_MAIN_BLOCK = 3'd3;
    localparam logic [2:0] ST_MAIN_SLEEP = 3'd4;
    localparam logic [2:0] ST_ZERO_SLEEP = 3'd5;
    localparam logic [2:0] ST_FULL = 3'd6;
    localparam logic [2:0] ST_HALTED = 3'd7;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // The sum is always below twice the slot count.
    function automatic slot_idx_t wrap(input slot_sum_t s);
        slot_sum_t r;
        r = (s >= slot_sum_t'(THREAD_SLOTS)) ? s - slot_sum_t'(THREAD_SLOTS) : s;
        return slot_idx_t'(r);
    endfunction

    function automatic slot_entry_t reset_entry(input slot_idx_t idx);
        slot_entry_t e;
        e.state = (idx == '0) ? SLOT_RUNNING : SLOT_UNUSED;
        e.mark = 1'b0;
        e.quanta = (idx == '0) ? 32'd1 : 32'd0;
        e.wake = 32'd0;
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== src/rrts_ram.sv =====
// Generic single-write, single-read RAM with a registered read.
// No dependencies.
`default_nettype none

module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/round_robin_thread_scheduler_core.sv =====
// Top level of the round-robin thread scheduler.
// Depends on rrts_pkg and rrts_ram.
`default_nettype none

// A command is taken when start is high and busy is low; its result appears for one cycle
// with done high and cannot be held off. A tick, or a yield of the running thread, scans
// the slot table, reading and then checking one slot at a time, and then switches to the
// head of the ready queue if it holds a thread; removing a thread from the ready queue
// first walks and shifts the queue, and spawn searches the table for a free slot. The
// longest command is terminating the running thread. The single read port of the slot
// table memory is why the slots are read one at a time.
module round_robin_thread_scheduler_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  operation,
    input  wire logic [4:0]  thread_id,
    input  wire logic [15:0] sleep_quanta,
    output logic             done,
    output logic [2:0]       status,
    output logic [31:0]      value,
    output logic [3:0]       running_thread,
    output logic             switched,
    output logic [31:0]      total_quanta
);

    typedef enum logic [4:0] {
        S_IDLE, S_T_CK, S_B_CK, S_R_CK, S_S_CK, S_Q_CK, S_SP_RD, S_SP_EX,
        S_RM_RD, S_RM_CK, S_SH_RD, S_SH_WR, S_POST, S_SC_RD, S_SC_EX, S_POP,
        S_POP_WT, S_CUR_RD, S_CUR_WR, S_NX_RD, S_NX_WR, S_TK_RD, S_TK_WR
    } fsm_t;

    fsm_t state_reg;
    logic [2:0] op_reg;
    logic [15:0] nq_reg;
    rrts_pkg::slot_idx_t tgt_reg;
    rrts_pkg::slot_idx_t idx_reg;
    rrts_pkg::slot_cnt_t pos_reg;
    rrts_pkg::slot_idx_t next_reg;
    logic tick_reg;
    rrts_pkg::slot_idx_t head_reg;
    rrts_pkg::slot_cnt_t count_reg;
    rrts_pkg::slot_idx_t run_reg;
    logic [31:0] elapsed_reg;
    logic halted_reg;
    logic [rrts_pkg::THREAD_SLOTS-1:0] valid_reg;
    logic done_reg;
    logic [2:0] status_reg;
    logic [31:0] value_reg;
    logic switched_reg;
    rrts_pkg::slot_idx_t raddr_reg;

    logic slot_we;
    rrts_pkg::slot_idx_t slot_waddr;
    rrts_pkg::slot_entry_t slot_wdata;
    rrts_pkg::slot_idx_t slot_raddr;
    logic [rrts_pkg::SLOT_W-1:0] slot_q;
    rrts_pkg::slot_entry_t rd;

    logic fifo_we;
    rrts_pkg::slot_idx_t fifo_waddr;
    rrts_pkg::slot_idx_t fifo_wdata;
    rrts_pkg::slot_idx_t fifo_raddr;
    rrts_pkg::slot_idx_t fifo_q;

    logic push_en;
    logic push_ok;
    rrts_pkg::slot_idx_t push_val;
    logic exists;
    logic wake_hit;
    logic resume_ok;
    logic id_valid;
    logic [32:0] wake_sum;
    logic [31:0] wake_sat;

    rrts_ram #(.WIDTH(rrts_pkg::SLOT_W), .DEPTH(rrts_pkg::THREAD_SLOTS)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_q)
    );

    rrts_ram #(.WIDTH(rrts_pkg::IDX_W), .DEPTH(rrts_pkg::THREAD_SLOTS)) u_fifo_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (fifo_wdata),
        .raddr (fifo_raddr),
        .rdata (fifo_q)
    );

    always_ff @(posedge clk)
    begin
        raddr_reg <= slot_raddr;
    end

    assign rd = valid_reg[raddr_reg] ? rrts_pkg::slot_entry_t'(slot_q)
                                     : rrts_pkg::reset_entry(raddr_reg);
    assign exists = rd.state != rrts_pkg::SLOT_UNUSED;
    assign wake_hit = (rd.state == rrts_pkg::SLOT_BLOCKED) && (rd.wake != 32'd0)
                      && (elapsed_reg > rd.wake) && !rd.mark;
    assign resume_ok = (rd.state == rrts_pkg::SLOT_BLOCKED)
                       && ((rd.wake == 32'd0) || (elapsed_reg > rd.wake));
    assign id_valid = int'(thread_id) < rrts_pkg::THREAD_SLOTS;
    assign wake_sum = {1'b0, elapsed_reg} + {17'd0, nq_reg};
    assign wake_sat = wake_sum[32] ? 32'hFFFF_FFFF : wake_sum[31:0];
    assign push_ok = push_en && (count_reg < rrts_pkg::slot_cnt_t'(rrts_pkg::THREAD_SLOTS));

    always_comb
    begin
        slot_we = 1'b0;
        slot_wdata = rd;
        slot_waddr = tgt_reg;
        slot_raddr = tgt_reg;
        push_en = 1'b0;
        push_val = tgt_reg;
        fifo_raddr = head_reg;
        case (state_reg)
            S_IDLE:
            begin
                slot_raddr = (operation == rrts_pkg::OP_SLEEP) ? run_reg
                                                               : rrts_pkg::slot_idx_t'(thread_id);
            end
            S_T_CK:
            begin
                if (exists && (tgt_reg != '0))
                begin
                    slot_we = 1'b1;
                    slot_wdata.state = rrts_pkg::SLOT_UNUSED;
                    slot_wdata.mark = 1'b0;
                end
            end
            S_B_CK:
            begin
                if (exists && !rd.mark)
                begin
                    slot_we = 1'b1;
                    slot_wdata.mark = 1'b1;
                    if ((rd.state == rrts_pkg::SLOT_READY) || (rd.state == rrts_pkg::SLOT_RUNNING))
                    begin
                        slot_wdata.state = rrts_pkg::SLOT_BLOCKED;
                    end
                end
            end
            S_R_CK:
            begin
                if (exists && rd.mark)
                begin
                    slot_we = 1'b1;
                    slot_wdata.mark = 1'b0;
                    if (resume_ok)
                    begin
                        slot_wdata.state = rrts_pkg::SLOT_READY;
                        slot_wdata.wake = 32'd0;
                        push_en = 1'b1;
                    end
                end
            end
            S_S_CK:
            begin
                slot_we = 1'b1;
                slot_wdata.wake = wake_sat;
                slot_wdata.state = rrts_pkg::SLOT_BLOCKED;
            end
            S_SP_RD, S_SC_RD:
            begin
                slot_raddr = idx_reg;
            end
            S_SP_EX:
            begin
                slot_waddr = idx_reg;
                push_val = idx_reg;
                if (!exists)
                begin
                    slot_we = 1'b1;
                    slot_wdata = '{rrts_pkg::SLOT_READY, 1'b0, 32'd0, 32'd0};
                    push_en = 1'b1;
                end
            end
            S_SC_EX:
            begin
                slot_waddr = idx_reg;
                push_val = idx_reg;
                if (wake_hit)
                begin
                    slot_we = 1'b1;
                    slot_wdata.state = rrts_pkg::SLOT_READY;
                    slot_wdata.wake = 32'd0;
                    push_en = 1'b1;
                end
            end
            S_RM_RD:
            begin
                fifo_raddr = rrts_pkg::wrap(rrts_pkg::slot_sum_t'(head_reg)
                                            + rrts_pkg::slot_sum_t'(pos_reg));
            end
            S_SH_RD:
            begin
                fifo_raddr = rrts_pkg::wrap(rrts_pkg::slot_sum_t'(head_reg)
                                            + rrts_pkg::slot_sum_t'(pos_reg)
                                            + rrts_pkg::slot_sum_t'(1));
            end
            S_CUR_RD, S_TK_RD:
            begin
                slot_raddr = run_reg;
            end
            S_CUR_WR:
            begin
                slot_waddr = run_reg;
                push_val = run_reg;
                if (rd.state == rrts_pkg::SLOT_RUNNING)
                begin
                    slot_we = 1'b1;
                    slot_wdata.state = rrts_pkg::SLOT_READY;
                    push_en = !rd.mark;
                end
            end
            S_NX_RD:
            begin
                slot_raddr = next_reg;
            end
            S_NX_WR:
            begin
                slot_waddr = next_reg;
                slot_we = 1'b1;
                slot_wdata.state = rrts_pkg::SLOT_RUNNING;
                slot_wdata.quanta = rrts_pkg::sat_inc(rd.quanta);
            end
            S_TK_WR:
            begin
                slot_waddr = run_reg;
                slot_we = 1'b1;
                slot_wdata.quanta = rrts_pkg::sat_inc(rd.quanta);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == S_SH_WR)
        begin
            fifo_we = 1'b1;
            fifo_waddr = rrts_pkg::wrap(rrts_pkg::slot_sum_t'(head_reg)
                                        + rrts_pkg::slot_sum_t'(pos_reg));
            fifo_wdata = fifo_q;
        end
        else
        begin
            fifo_we = push_ok;
            fifo_waddr = rrts_pkg::wrap(rrts_pkg::slot_sum_t'(head_reg)
                                        + rrts_pkg::slot_sum_t'(count_reg));
            fifo_wdata = push_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= rrts_pkg::OP_TICK;
            nq_reg <= '0;
            tgt_reg <= '0;
            idx_reg <= '0;
            pos_reg <= '0;
            next_reg <= '0;
            tick_reg <= 1'b0;
            head_reg <= '0;
            count_reg <= '0;
            run_reg <= '0;
            elapsed_reg <= 32'd1;
            halted_reg <= 1'b0;
            valid_reg <= '0;
            done_reg <= 1'b0;
            status_reg <= rrts_pkg::ST_OK;
            value_reg <= '0;
            switched_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (slot_we)
            begin
                valid_reg[slot_waddr] <= 1'b1;
            end
            if (push_ok)
            begin
                count_reg <= count_reg + rrts_pkg::slot_cnt_t'(1);
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg <= operation;
                        nq_reg <= sleep_quanta;
                        tgt_reg <= (operation == rrts_pkg::OP_SLEEP) ? run_reg
                                   : rrts_pkg::slot_idx_t'(thread_id);
                        status_reg <= rrts_pkg::ST_OK;
                        value_reg <= '0;
                        switched_reg <= 1'b0;
                        tick_reg <= 1'b0;
                        idx_reg <= '0;
                        pos_reg <= '0;
                        if (halted_reg)
                        begin
                            status_reg <= rrts_pkg::ST_HALTED;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            case (operation)
                                rrts_pkg::OP_TICK:
                                begin
                                    tick_reg <= 1'b1;
                                    state_reg <= S_SC_RD;
                                end
                                rrts_pkg::OP_SPAWN:
                                begin
                                    idx_reg <= rrts_pkg::slot_idx_t'(1);
                                    state_reg <= S_SP_RD;
                                end
                                rrts_pkg::OP_TERMINATE, rrts_pkg::OP_RESUME, rrts_pkg::OP_QUERY:
                                begin
                                    if (!id_valid)
                                    begin
                                        status_reg <= rrts_pkg::ST_BAD_ID;
                                        done_reg <= 1'b1;
                                    end
                                    else if (operation == rrts_pkg::OP_TERMINATE)
                                    begin
                                        state_reg <= S_T_CK;
                                    end
                                    else if (operation == rrts_pkg::OP_RESUME)
                                    begin
                                        state_reg <= S_R_CK;
                                    end
                                    else
                                    begin
                                        state_reg <= S_Q_CK;
                                    end
                                end
                                rrts_pkg::OP_BLOCK:
                                begin
                                    if (thread_id == 5'd0)
                                    begin
                                        status_reg <= rrts_pkg::ST_MAIN_BLOCK;
                                        done_reg <= 1'b1;
                                    end
                                    else if (!id_valid)
                                    begin
                                        status_reg <= rrts_pkg::ST_BAD_ID;
                                        done_reg <= 1'b1;
                                    end
                                    else
                                    begin
                                        state_reg <= S_B_CK;
                                    end
                                end
                                rrts_pkg::OP_SLEEP:
                                begin
                                    if (run_reg == '0)
                                    begin
                                        status_reg <= rrts_pkg::ST_MAIN_SLEEP;
                                        done_reg <= 1'b1;
                                    end
                                    else if (sleep_quanta == 16'd0)
                                    begin
                                        status_reg <= rrts_pkg::ST_ZERO_SLEEP;
                                        done_reg <= 1'b1;
                                    end
                                    else
                                    begin
                                        state_reg <= S_S_CK;
                                    end
                                end
                                default:
                                begin
                                    done_reg <= 1'b1;
                                end
                            endcase
                        end
                    end
                end
                S_T_CK:
                begin
                    if (!exists)
                    begin
                        status_reg <= rrts_pkg::ST_NO_THREAD;
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (tgt_reg == '0)
                    begin
                        halted_reg <= 1'b1;
                        status_reg <= rrts_pkg::ST_HALTED;
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_RM_RD;
                    end
                end
                S_B_CK:
                begin
                    if (!exists)
                    begin
                        status_reg <= rrts_pkg::ST_NO_THREAD;
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (!rd.mark && (rd.state == rrts_pkg::SLOT_READY))
                    begin
                        state_reg <= S_RM_RD;
                    end
                    else
                    begin
                        state_reg <= S_POST;
                    end
                end
                S_R_CK:
                begin
                    if (!exists)
                    begin
                        status_reg <= rrts_pkg::ST_NO_THREAD;
                    end
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_Q_CK:
                begin
                    if (!exists)
                    begin
                        status_reg <= rrts_pkg::ST_NO_THREAD;
                    end
                    else
                    begin
                        value_reg <= rd.quanta;
                    end
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_S_CK:
                begin
                    state_reg <= S_SC_RD;
                end
                S_SP_RD:
                begin
                    state_reg <= S_SP_EX;
                end
                S_SP_EX:
                begin
                    if (!exists)
                    begin
                        value_reg <= 32'(idx_reg);
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (int'(idx_reg) == rrts_pkg::THREAD_SLOTS - 1)
                    begin
                        status_reg <= rrts_pkg::ST_FULL;
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + rrts_pkg::slot_idx_t'(1);
                        state_reg <= S_SP_RD;
                    end
                end
                S_RM_RD:
                begin
                    state_reg <= (pos_reg >= count_reg) ? S_POST : S_RM_CK;
                end
                S_RM_CK:
                begin
                    if (fifo_q == tgt_reg)
                    begin
                        state_reg <= S_SH_RD;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + rrts_pkg::slot_cnt_t'(1);
                        state_reg <= S_RM_RD;
                    end
                end
                S_SH_RD:
                begin
                    if ((rrts_pkg::slot_sum_t'(pos_reg) + rrts_pkg::slot_sum_t'(1))
                        >= rrts_pkg::slot_sum_t'(count_reg))
                    begin
                        count_reg <= count_reg - rrts_pkg::slot_cnt_t'(1);
                        state_reg <= S_POST;
                    end
                    else
                    begin
                        state_reg <= S_SH_WR;
                    end
                end
                S_SH_WR:
                begin
                    pos_reg <= pos_reg + rrts_pkg::slot_cnt_t'(1);
                    state_reg <= S_SH_RD;
                end
                S_POST:
                begin
                    if (tgt_reg == run_reg)
                    begin
                        idx_reg <= '0;
                        state_reg <= S_SC_RD;
                    end
                    else
                    begin
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_SC_RD:
                begin
                    state_reg <= S_SC_EX;
                end
                S_SC_EX:
                begin
                    if (int'(idx_reg) == rrts_pkg::THREAD_SLOTS - 1)
                    begin
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + rrts_pkg::slot_idx_t'(1);
                        state_reg <= S_SC_RD;
                    end
                end
                S_POP:
                begin
                    if (count_reg != '0)
                    begin
                        state_reg <= S_POP_WT;
                    end
                    else if (tick_reg)
                    begin
                        state_reg <= S_TK_RD;
                    end
                    else
                    begin
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_POP_WT:
                begin
                    next_reg <= fifo_q;
                    head_reg <= rrts_pkg::wrap(rrts_pkg::slot_sum_t'(head_reg)
                                               + rrts_pkg::slot_sum_t'(1));
                    count_reg <= count_reg - rrts_pkg::slot_cnt_t'(1);
                    elapsed_reg <= rrts_pkg::sat_inc(elapsed_reg);
                    state_reg <= S_CUR_RD;
                end
                S_CUR_RD:
                begin
                    state_reg <= S_CUR_WR;
                end
                S_CUR_WR:
                begin
                    state_reg <= S_NX_RD;
                end
                S_NX_RD:
                begin
                    state_reg <= S_NX_WR;
                end
                S_NX_WR:
                begin
                    run_reg <= next_reg;
                    switched_reg <= 1'b1;
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_TK_RD:
                begin
                    elapsed_reg <= rrts_pkg::sat_inc(elapsed_reg);
                    state_reg <= S_TK_WR;
                end
                S_TK_WR:
                begin
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;
    assign status = status_reg;
    assign value = value_reg;
    assign running_thread = 4'(run_reg);
    assign switched = switched_reg;
    assign total_quanta = elapsed_reg;

endmodule

`default_nettype wire

// ===== src/rrts_checker.sv =====
// Port-level checks for the round-robin thread scheduler, bound to the top level.
// Depends on rrts_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rrts_port_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic [2:0] status,
    input wire logic       switched
);

    `ASSERT_IMPLY(a_done_not_busy, clk, rst_n, done, !busy)
    `ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || done)
    `ASSERT_IMPLY(a_halted_no_switch, clk, rst_n, done && (status == rrts_pkg::ST_HALTED), !switched)
    `ASSERT_IMPLY(a_switch_ok, clk, rst_n, done && switched, status == rrts_pkg::ST_OK)

endmodule

bind round_robin_thread_scheduler_core rrts_port_checker u_rrts_port_checker (.*);

`default_nettype wire
